/* rtl/cmlt_pkg.sv */
// Shared types and constants for the case mapping table lookup unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package cmlt_pkg;

    localparam int CP_W    = 21;
    localparam int ENTRY_W = 3 * CP_W;
    localparam int DCNT_W  = 12;
    localparam int TCNT_W  = 5;
    localparam int CFG_W   = 12;

    localparam logic [CP_W-1:0] MAX_SCALAR    = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO       = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI       = 21'h00DFFF;
    localparam logic [CP_W-1:0] ASCII_SHIFT   = 21'd32;
    localparam logic [CP_W-1:0] ASCII_UPPER_A = 21'h41;
    localparam logic [CP_W-1:0] ASCII_UPPER_Z = 21'h5A;
    localparam logic [CP_W-1:0] ASCII_LOWER_A = 21'h61;
    localparam logic [CP_W-1:0] ASCII_LOWER_Z = 21'h7A;

    localparam logic [1:0] REQ_CONVERT      = 2'd0;
    localparam logic [1:0] REQ_LOAD_DEFAULT = 2'd1;
    localparam logic [1:0] REQ_LOAD_TURKIC  = 2'd2;

    localparam logic [1:0] CFG_POSIX_MODE     = 2'd0;
    localparam logic [1:0] CFG_TURKIC_PROFILE = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_USED   = 2'd2;
    localparam logic [1:0] CFG_TURKIC_USED    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_T_START,
        ST_D_START,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        RES_QUICK,
        RES_CP,
        RES_ENTRY
    } t_res_sel;

    typedef struct packed {
        logic     take;
        logic     start_t;
        logic     start_d;
        logic     search;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic in_conv;
        logic quick;
        logic turkic_on;
        logic t_empty;
        logic d_empty;
        logic hit;
        logic exhausted;
        logic in_turkic;
        logic out_free;
    } t_status;

endpackage

/* rtl/cmlt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for both case tables of the lookup unit.
module cmlt_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cmlt_ctrl.sv */
// Sequencing state machine of the case mapping table lookup unit.
// Depends on cmlt_pkg; drives the datapath by command word and reads its status.
module cmlt_ctrl import cmlt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_st.in_conv) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (i_st.quick) begin
                    n_state = ST_FINISH;
                end else if (i_st.turkic_on) begin
                    n_state = ST_T_START;
                end else begin
                    n_state = ST_D_START;
                end
            end
            ST_T_START: begin
                n_state = i_st.t_empty ? ST_D_START : ST_SEARCH;
            end
            ST_D_START: begin
                n_state = i_st.d_empty ? ST_FINISH : ST_SEARCH;
            end
            ST_SEARCH: begin
                if (i_st.hit) begin
                    n_state = ST_FINISH;
                end else if (i_st.exhausted) begin
                    n_state = i_st.in_turkic ? ST_D_START : ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_st.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            ST_PREP: begin
                if (i_st.quick) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_QUICK;
                end
            end
            ST_T_START: begin
                o_cmd.start_t = !i_st.t_empty;
            end
            ST_D_START: begin
                if (i_st.d_empty) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_CP;
                end else begin
                    o_cmd.start_d = 1'b1;
                end
            end
            ST_SEARCH: begin
                if (i_st.hit) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_ENTRY;
                end else if (i_st.exhausted) begin
                    if (!i_st.in_turkic) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_CP;
                    end
                end else begin
                    o_cmd.search = 1'b1;
                end
            end
            ST_FINISH: begin
                o_cmd.out_load = i_st.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/cmlt_dp.sv */
// Datapath of the case mapping table lookup unit: configuration registers,
// both case tables, the binary search bounds and the output register.
// Depends on cmlt_pkg and cmlt_ram.
module cmlt_dp import cmlt_pkg::*; #(
    parameter int DEFAULT_ENTRIES = 2048,
    parameter int TURKIC_ENTRIES  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_st,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_req_type,
    input  logic [CP_W-1:0]   i_code_point,
    input  logic              i_to_upper,
    input  logic [10:0]       i_entry_index,
    input  logic [CP_W-1:0]   i_entry_upper,
    input  logic [CP_W-1:0]   i_entry_lower,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CP_W-1:0]   o_mapped_code_point
);

    localparam int MAXD = (DEFAULT_ENTRIES > TURKIC_ENTRIES) ? DEFAULT_ENTRIES : TURKIC_ENTRIES;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int DAW  = (DEFAULT_ENTRIES > 1) ? $clog2(DEFAULT_ENTRIES) : 1;
    localparam int TAW  = (TURKIC_ENTRIES > 1) ? $clog2(TURKIC_ENTRIES) : 1;
    localparam int XW   = (DAW > 11) ? DAW : ((TAW > 11) ? TAW : 11);

    logic              r_posix;
    logic              r_turkic;
    logic [DCNT_W-1:0] r_dcnt;
    logic [TCNT_W-1:0] r_tcnt;

    logic [CP_W-1:0]   r_cp;
    logic              r_up;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_hi;
    logic [CW-1:0]     r_mid;
    logic              r_tab;
    logic [CP_W-1:0]   r_res;
    logic [CP_W-1:0]   r_out;
    logic              r_out_valid;

    logic [CW-1:0]     cnt_d_sat;
    logic [CW-1:0]     cnt_t_sat;
    logic [CW-1:0]     start_n;
    logic [CW-1:0]     start_mid;
    logic [CW-1:0]     n_lo;
    logic [CW-1:0]     n_hi;
    logic [CW-1:0]     n_mid;
    logic [CW-1:0]     rd_mid;
    logic [XW-1:0]     idx_x;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata_d;
    logic [ENTRY_W-1:0] rdata_t;
    logic [ENTRY_W-1:0] entry;
    logic [CP_W-1:0]   e_key;
    logic [CP_W-1:0]   e_val;
    logic              key_gt;
    logic              scalar_ok;
    logic [CP_W-1:0]   quick_val;
    logic              we_d;
    logic              we_t;
    logic              starting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_posix  <= 1'b1;
            r_turkic <= 1'b0;
            r_dcnt   <= '0;
            r_tcnt   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POSIX_MODE:     r_posix  <= i_cfg_data[0];
                CFG_TURKIC_PROFILE: r_turkic <= i_cfg_data[0];
                CFG_DEFAULT_USED:   r_dcnt   <= i_cfg_data[DCNT_W-1:0];
                CFG_TURKIC_USED:    r_tcnt   <= i_cfg_data[TCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cnt_d_sat = (32'(r_dcnt) < 32'(DEFAULT_ENTRIES)) ? CW'(r_dcnt) : CW'(DEFAULT_ENTRIES);
    assign cnt_t_sat = (32'(r_tcnt) < 32'(TURKIC_ENTRIES)) ? CW'(r_tcnt) : CW'(TURKIC_ENTRIES);

    assign idx_x = XW'(i_entry_index);
    assign wdata = {i_code_point, i_entry_upper, i_entry_lower};
    assign we_d  = i_cmd.take && (i_req_type == REQ_LOAD_DEFAULT)
                   && (32'(i_entry_index) < 32'(DEFAULT_ENTRIES));
    assign we_t  = i_cmd.take && (i_req_type == REQ_LOAD_TURKIC)
                   && (32'(i_entry_index) < 32'(TURKIC_ENTRIES));

    // The probe address goes to the RAM's registered read port, ahead of the compare that uses it.
    assign starting  = i_cmd.start_t || i_cmd.start_d;
    assign start_n   = i_cmd.start_t ? cnt_t_sat : cnt_d_sat;
    assign start_mid = start_n >> 1;

    assign entry  = r_tab ? rdata_t : rdata_d;
    assign e_key  = entry[ENTRY_W-1 -: CP_W];
    assign e_val  = r_up ? entry[2*CP_W-1 -: CP_W] : entry[CP_W-1:0];
    assign key_gt = e_key > r_cp;
    assign n_lo   = key_gt ? r_lo : r_mid + CW'(1);
    assign n_hi   = key_gt ? r_mid : r_hi;
    assign n_mid  = n_lo + ((n_hi - n_lo) >> 1);
    assign rd_mid = starting ? start_mid : n_mid;

    cmlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEFAULT_ENTRIES)
    ) u_default_ram (
        .i_clk   (i_clk),
        .i_we    (we_d),
        .i_waddr (idx_x[DAW-1:0]),
        .i_wdata (wdata),
        .i_raddr (rd_mid[DAW-1:0]),
        .o_rdata (rdata_d)
    );

    cmlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TURKIC_ENTRIES)
    ) u_turkic_ram (
        .i_clk   (i_clk),
        .i_we    (we_t),
        .i_waddr (idx_x[TAW-1:0]),
        .i_wdata (wdata),
        .i_raddr (rd_mid[TAW-1:0]),
        .o_rdata (rdata_t)
    );

    assign scalar_ok = (r_cp <= MAX_SCALAR) && !((r_cp >= SURR_LO) && (r_cp <= SURR_HI));

    always_comb begin
        quick_val = r_cp;
        if (scalar_ok && r_posix) begin
            if (r_up && (r_cp >= ASCII_LOWER_A) && (r_cp <= ASCII_LOWER_Z)) begin
                quick_val = r_cp - ASCII_SHIFT;
            end else if (!r_up && (r_cp >= ASCII_UPPER_A) && (r_cp <= ASCII_UPPER_Z)) begin
                quick_val = r_cp + ASCII_SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cp <= i_code_point;
            r_up <= i_to_upper;
        end
        if (starting) begin
            r_lo  <= '0;
            r_hi  <= start_n;
            r_mid <= start_mid;
            r_tab <= i_cmd.start_t;
        end else if (i_cmd.search) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_mid;
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RES_QUICK: r_res <= quick_val;
                RES_ENTRY: r_res <= e_val;
                default:   r_res <= r_cp;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_st.in_conv   = (i_req_type == REQ_CONVERT);
        o_st.quick     = !scalar_ok || r_posix;
        o_st.turkic_on = r_turkic;
        o_st.t_empty   = (cnt_t_sat == '0);
        o_st.d_empty   = (cnt_d_sat == '0);
        o_st.hit       = (e_key == r_cp);
        o_st.exhausted = (n_lo >= n_hi);
        o_st.in_turkic = r_tab;
        o_st.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid         = r_out_valid;
    assign o_mapped_code_point = r_out;

endmodule

/* rtl/case_map_table_lookup_unit.sv */
// Top level of the case mapping table lookup unit.
// Depends on cmlt_pkg, cmlt_ctrl, cmlt_dp and cmlt_ram.
//
// Converts one code point per convert word to upper or lower case. Load words
// write one entry of the default or Turkic table and give no result. For a
// convert word that is not a scalar, or that runs in POSIX mode, the result is
// loaded in the prepare state and moved to the output register in the finish
// state once that register is free. The next word can be accepted in the cycle
// the result turns valid. A table lookup binary-searches each table with one
// RAM probe per cycle, using up to floor(log2(count)) + 1 probes per table. It
// also passes through a prepare state, a start state for each table and a
// finish state. The single read port of each table RAM sets the pace of the
// search. Tables must be sorted by key and written below the configured counts
// before use. A finished result waits in the output register while the next
// word is accepted. Configuration writes are always ready.
module case_map_table_lookup_unit import cmlt_pkg::*; #(
    parameter int DEFAULT_ENTRIES = 2048,
    parameter int TURKIC_ENTRIES  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_req_type,
    input  logic [CP_W-1:0]   i_code_point,
    input  logic              i_to_upper,
    input  logic [10:0]       i_entry_index,
    input  logic [CP_W-1:0]   i_entry_upper,
    input  logic [CP_W-1:0]   i_entry_lower,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CP_W-1:0]   o_mapped_code_point
);

    t_cmd    cmd;
    t_status st;

    assign o_cfg_ready = 1'b1;

    cmlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    cmlt_dp #(
        .DEFAULT_ENTRIES (DEFAULT_ENTRIES),
        .TURKIC_ENTRIES  (TURKIC_ENTRIES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_st                (st),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_req_type          (i_req_type),
        .i_code_point        (i_code_point),
        .i_to_upper          (i_to_upper),
        .i_entry_index       (i_entry_index),
        .i_entry_upper       (i_entry_upper),
        .i_entry_lower       (i_entry_lower),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_mapped_code_point (o_mapped_code_point)
    );

endmodule
